>>> src/sqt_pkg.sv
// Shared types and constants of the shell quote tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sqt_pkg;

    // Lexer modes.
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SQ     = 3'd1;
    localparam logic [2:0] MODE_DQ     = 3'd2;
    localparam logic [2:0] MODE_DQ_ESC = 3'd3;
    localparam logic [2:0] MODE_BS     = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_WORD_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    // Most results a single input byte can cause.
    localparam int MaxResults = 4;
    localparam int IdxW       = $clog2(MaxResults);
    localparam int CntW       = $clog2(MaxResults + 1);

    // One result: flags bit 0 redir_out, 1 redir_err, 2 app_out, 3 app_err.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] word_byte;
        logic [3:0] flags;
    } res_t;

    // All results of one input byte, in emission order.
    typedef struct packed {
        logic [CntW-1:0]            count;
        res_t [MaxResults-1:0]      items;
    } res_list_t;

endpackage

`default_nettype wire

>>> src/shell_quote_tokenizer_core.sv
// Top level of the shell quote tokenizer: input register, lexer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Shell-style word tokenizer, one command-line byte per request.
//
// The slave channel carries one byte in s_tdata with s_tlast on the final
// byte of a line. The master channel returns the results of each byte in
// order: m_tuser gives the kind (word byte, word end, line end with flags),
// m_tdata carries the word byte and the four redirect flags, and m_tlast
// marks the last result caused by one input byte. A byte may cause no result
// (quote characters, separators between words, a bare backslash).
//
// A byte is held in an input register, then the lexer works out all of its
// results combinationally and loads them into the result register, which
// presents the first result. While the receiver is ready, a byte with at
// most one result sustains one byte per cycle; a byte with several results
// holds the result register until each is taken, with at most four (escape
// in double quotes plus word end plus line end).
//
// Reset (aresetn low at a clock edge) empties both registers and returns the
// lexer to the unquoted mode with no open word and all flags clear. When the
// receiver stalls, the result register holds its request and the input
// register fills, after which s_tready drops until results drain.
module shell_quote_tokenizer_core
    import sqt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // line_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] word_byte, [8] redir_out, [9] redir_err,
                                        // [10] app_out, [11] app_err, [15:12] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // run_last
);

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       ser_ready;
    logic       step;
    res_list_t  res_list;

    // The lexer state advances exactly when a held byte moves into the result register.
    assign step     = in_valid_reg && ser_ready;
    assign s_tready = !in_valid_reg || ser_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    sqt_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .ch       (ch_reg),
        .line_end (last_reg),
        .res_list (res_list)
    );

    sqt_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_list  (res_list),
        .load_ready (ser_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/sqt_lexer.sv
// Lexer state and the per-byte result list of the shell quote tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module sqt_lexer
    import sqt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] ch,
    input  wire logic       line_end,
    output res_list_t       res_list
);

    typedef struct packed {
        logic [2:0]  len;
        logic [23:0] head;
    } word_t;

    // Append one byte: the first three bytes are kept, the length saturates at 7.
    function automatic word_t add_byte(word_t w, logic [7:0] b);
        word_t r;
        r = w;
        if (w.len < 3'd3) begin
            r.head = w.head | ({16'd0, b} << {w.len[1:0], 3'b000});
        end
        if (w.len != 3'd7) begin
            r.len = w.len + 3'd1;
        end
        return r;
    endfunction

    logic [2:0] mode_reg, mode_next;
    word_t      word_reg, word_next;
    logic [3:0] flags_reg, flags_next;

    logic       add_a, add_b, sep;
    word_t      word_a, word_b;
    logic [3:0] flags_mid;
    logic       word_end;
    logic [CntW-1:0] pos;

    always_comb begin
        mode_next = mode_reg;
        add_a     = 1'b0;
        add_b     = 1'b0;
        sep       = 1'b0;
        case (mode_reg)
            MODE_BS: begin
                add_b     = 1'b1;
                mode_next = MODE_NORMAL;
            end
            MODE_DQ_ESC: begin
                // Only the special characters drop the backslash.
                add_a     = !(ch inside {8'h5C, 8'h22, 8'h24, 8'h60, 8'h0A});
                add_b     = 1'b1;
                mode_next = MODE_DQ;
            end
            MODE_SQ: begin
                if (ch == 8'h27) begin
                    mode_next = MODE_NORMAL;
                end else begin
                    add_b = 1'b1;
                end
            end
            MODE_DQ: begin
                if (ch == 8'h22) begin
                    mode_next = MODE_NORMAL;
                end else if (ch == 8'h5C) begin
                    mode_next = MODE_DQ_ESC;
                end else begin
                    add_b = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                if (ch == 8'h27) begin
                    mode_next = MODE_SQ;
                end else if (ch == 8'h22) begin
                    mode_next = MODE_DQ;
                end else if (ch == 8'h5C) begin
                    mode_next = MODE_BS;
                end else if (ch inside {8'h20, 8'h09}) begin
                    sep = 1'b1;
                end else begin
                    add_b = 1'b1;
                end
            end
        endcase

        word_a = add_a ? add_byte(word_reg, 8'h5C) : word_reg;
        word_b = add_b ? add_byte(word_a, ch) : word_a;

        // Redirect operators are recognized only when a separator closes the word.
        flags_mid = flags_reg;
        if (sep) begin
            if ((word_b.len == 3'd1 && word_b.head == 24'h00003E) ||
                (word_b.len == 3'd2 && word_b.head == 24'h003E31)) begin
                flags_mid[0] = 1'b1;
            end else if (word_b.len == 3'd2 && word_b.head == 24'h003E32) begin
                flags_mid[1] = 1'b1;
            end else if ((word_b.len == 3'd2 && word_b.head == 24'h003E3E) ||
                         (word_b.len == 3'd3 && word_b.head == 24'h3E3E31)) begin
                flags_mid[2] = 1'b1;
            end else if (word_b.len == 3'd3 && word_b.head == 24'h3E3E32) begin
                flags_mid[3] = 1'b1;
            end
        end
        word_end = (sep || line_end) && (word_b.len != 3'd0);

        res_list = '0;
        pos      = '0;
        if (add_a) begin
            res_list.items[pos[IdxW-1:0]] = '{KIND_BYTE, 8'h5C, 4'd0};
            pos = pos + 1'b1;
        end
        if (add_b) begin
            res_list.items[pos[IdxW-1:0]] = '{KIND_BYTE, ch, 4'd0};
            pos = pos + 1'b1;
        end
        if (word_end) begin
            res_list.items[pos[IdxW-1:0]] = '{KIND_WORD_END, 8'd0, 4'd0};
            pos = pos + 1'b1;
        end
        if (line_end) begin
            res_list.items[pos[IdxW-1:0]] = '{KIND_LINE_END, 8'd0, flags_mid};
            pos = pos + 1'b1;
        end
        res_list.count = pos;

        if (line_end) begin
            mode_next  = MODE_NORMAL;
            word_next  = '0;
            flags_next = '0;
        end else if (sep) begin
            word_next  = '0;
            flags_next = flags_mid;
        end else begin
            word_next  = word_b;
            flags_next = flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            word_reg  <= '0;
            flags_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            word_reg  <= word_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sqt_serializer.sv
// Result register that hands out the results of one byte one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module sqt_serializer
    import sqt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load_valid,
    input  wire res_list_t  load_list,
    output logic            load_ready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic                        busy_reg;
    logic [CntW-1:0]             cnt_reg;
    logic [IdxW-1:0]             idx_reg;
    res_t [MaxResults-1:0]       items_reg;
    res_t                        cur;
    logic                        at_last;

    assign cur        = items_reg[idx_reg];
    assign at_last    = ({1'b0, idx_reg} + 1'b1) == cnt_reg;
    assign load_ready = !busy_reg || (m_tready && at_last);

    assign m_tvalid = busy_reg;
    assign m_tuser  = cur.kind;
    assign m_tlast  = at_last;
    assign m_tdata  = {4'd0, cur.flags, cur.word_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load_ready) begin
            busy_reg <= load_valid && (load_list.count != '0);
            idx_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            idx_reg  <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            cnt_reg   <= load_list.count;
            items_reg <= load_list.items;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the shell quote tokenizer: directed lines, random lines, random idling.
`timescale 1ns / 1ps

module tb;
    import sqt_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 6;
    // The result register sits behind the input register; this settle margin covers both.
    localparam int SETTLE_TICKS = 8;
    localparam int LIMIT_TICKS  = 200000;

    // Characters the lexer treats specially.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_FILLER = 8'h41;

    // Redirect operators as held in the first three bytes of a word, first byte lowest.
    localparam logic [23:0] OP_GT       = 24'h00003E;
    localparam logic [23:0] OP_ONE_GT   = 24'h003E31;
    localparam logic [23:0] OP_TWO_GT   = 24'h003E32;
    localparam logic [23:0] OP_GT_GT    = 24'h003E3E;
    localparam logic [23:0] OP_ONE_GTGT = 24'h3E3E31;
    localparam logic [23:0] OP_TWO_GTGT = 24'h3E3E32;

    // Bit positions in the sticky flag vector.
    localparam int FLAG_REDIR_OUT = 0;
    localparam int FLAG_REDIR_ERR = 1;
    localparam int FLAG_APP_OUT   = 2;
    localparam int FLAG_APP_ERR   = 3;

    typedef struct packed {
        res_t res;
        logic last;
    } token_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Lexer state of the bench's own model.
    logic [2:0]  lex_mode  = MODE_NORMAL;
    logic [2:0]  word_len  = 3'd0;
    logic [23:0] word_head = 24'h0;
    logic [3:0]  sticky    = 4'h0;

    res_t        step_tokens[$];
    token_t      pending_tokens[$];
    logic [7:0]  line_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int bytes_sent     = 0;
    int lines_sent     = 0;
    int tokens_checked = 0;
    int flagged_lines  = 0;

    shell_quote_tokenizer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] ch
        .s_tlast  (s_tlast),    // line_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] word_byte, [8] redir_out, [9] redir_err,
                                // [10] app_out, [11] app_err, [15:12] zero
        .m_tuser  (m_tuser),    // [1:0] kind
        .m_tlast  (m_tlast)     // run_last
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic void emit_token(logic [1:0] kind, logic [7:0] b, logic [3:0] flags);
        res_t r;
        r = '{kind: kind, word_byte: b, flags: flags};
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void append_word_byte(logic [7:0] b);
        if (word_len < 3'd3) begin
            word_head[8 * word_len +: 8] = b;
        end
        if (word_len < 3'd7) begin
            word_len = word_len + 3'd1;
        end
        emit_token(KIND_BYTE, b, 4'h0);
    endfunction

    // Only a word closed by a separator is matched against the operators.
    function automatic void close_word(logic at_separator);
        if (at_separator) begin
            if ((word_len == 3'd1 && word_head == OP_GT) ||
                (word_len == 3'd2 && word_head == OP_ONE_GT)) begin
                sticky[FLAG_REDIR_OUT] = 1'b1;
            end else if (word_len == 3'd2 && word_head == OP_TWO_GT) begin
                sticky[FLAG_REDIR_ERR] = 1'b1;
            end else if ((word_len == 3'd2 && word_head == OP_GT_GT) ||
                         (word_len == 3'd3 && word_head == OP_ONE_GTGT)) begin
                sticky[FLAG_APP_OUT] = 1'b1;
            end else if (word_len == 3'd3 && word_head == OP_TWO_GTGT) begin
                sticky[FLAG_APP_ERR] = 1'b1;
            end
        end
        if (word_len != 3'd0) begin
            emit_token(KIND_WORD_END, 8'h00, 4'h0);
        end
        word_len  = 3'd0;
        word_head = 24'h0;
    endfunction

    // Works out every token one accepted byte causes and queues them in order.
    function automatic void lex_byte(logic [7:0] ch, logic eol);
        token_t tok;
        step_tokens.delete();
        case (lex_mode)
            MODE_BS: begin
                append_word_byte(ch);
                lex_mode = MODE_NORMAL;
            end
            MODE_DQ_ESC: begin
                // Only these characters lose their backslash inside double quotes.
                if (!(ch inside {CH_BSLASH, CH_DQUOTE, CH_DOLLAR, CH_BTICK, CH_NL})) begin
                    append_word_byte(CH_BSLASH);
                end
                append_word_byte(ch);
                lex_mode = MODE_DQ;
            end
            MODE_SQ: begin
                if (ch == CH_SQUOTE) begin
                    lex_mode = MODE_NORMAL;
                end else begin
                    append_word_byte(ch);
                end
            end
            MODE_DQ: begin
                if (ch == CH_DQUOTE) begin
                    lex_mode = MODE_NORMAL;
                end else if (ch == CH_BSLASH) begin
                    lex_mode = MODE_DQ_ESC;
                end else begin
                    append_word_byte(ch);
                end
            end
            default: begin
                lex_mode = MODE_NORMAL;
                if (ch == CH_SQUOTE) begin
                    lex_mode = MODE_SQ;
                end else if (ch == CH_DQUOTE) begin
                    lex_mode = MODE_DQ;
                end else if (ch == CH_BSLASH) begin
                    lex_mode = MODE_BS;
                end else if (ch inside {CH_SPACE, CH_TAB}) begin
                    close_word(1'b1);
                end else begin
                    append_word_byte(ch);
                end
            end
        endcase
        // Line end closes any open quote silently and drops a pending backslash.
        if (eol) begin
            close_word(1'b0);
            emit_token(KIND_LINE_END, 8'h00, sticky);
            if (sticky != 4'h0) begin
                flagged_lines++;
            end
            lex_mode  = MODE_NORMAL;
            word_len  = 3'd0;
            word_head = 24'h0;
            sticky    = 4'h0;
        end
        foreach (step_tokens[i]) begin
            tok.res  = step_tokens[i];
            tok.last = (i == step_tokens.size() - 1);
            pending_tokens.insert(pending_tokens.size(), tok);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : token_check
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected token kind=%0d tdata=%h tlast=%b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (m_tuser !== want.res.kind ||
                    m_tdata !== {4'h0, want.res.flags, want.res.word_byte} ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: expected kind=%0d tdata=%h tlast=%b, %s",
                             $time, want.res.kind,
                             {4'h0, want.res.flags, want.res.word_byte}, want.last,
                             $sformatf("got kind=%0d tdata=%h tlast=%b",
                                       m_tuser, m_tdata, m_tlast));
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offers one byte, idling first at random, and returns once it is accepted.
    task automatic send_byte(input logic [7:0] ch, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        lex_byte(ch, eol);
        bytes_sent++;
    endtask

    task automatic send_line();
        int n;
        n = line_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(line_bytes[i], i == n - 1);
        end
        lines_sent++;
    endtask

    // The sender holds off until every outstanding token has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    function automatic void add_line_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_line_byte(s[i]);
        end
    endfunction

    function automatic logic [7:0] pick_separator();
        return $urandom_range(1) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(7))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_SQUOTE;
            3: return CH_DQUOTE;
            4: return CH_BSLASH;
            5: return ">";
            6: return "1";
            default: return "2";
        endcase
    endfunction

    // A redirect operator, sometimes wrapped in quotes, which still counts.
    function automatic void push_operator();
        logic [7:0] q;
        logic       wrap;
        q    = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        wrap = ($urandom_range(3) == 0);
        if (wrap) begin
            add_line_byte(q);
        end
        case ($urandom_range(5))
            0: push_text(">");
            1: push_text("1>");
            2: push_text("2>");
            3: push_text(">>");
            4: push_text("1>>");
            default: push_text("2>>");
        endcase
        if (wrap) begin
            add_line_byte(q);
        end
    endfunction

    // Plain words built mostly from operator characters, so many are near misses.
    function automatic void push_word();
        int n;
        n = $urandom_range(1, 9);
        repeat (n) begin
            case ($urandom_range(4))
                0: add_line_byte("1");
                1: add_line_byte("2");
                2: add_line_byte(">");
                3: add_line_byte("a");
                default: add_line_byte("z");
            endcase
        end
    endfunction

    // A quoted run of random bytes; the final token may leave its quote open.
    function automatic void push_quoted(logic [7:0] q, logic may_leave_open);
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 4);
        add_line_byte(q);
        repeat (n) begin
            b = 8'($urandom_range(255));
            if (q == CH_DQUOTE && $urandom_range(1)) begin
                add_line_byte(CH_BSLASH);
                case ($urandom_range(5))
                    0: b = CH_BSLASH;
                    1: b = CH_DQUOTE;
                    2: b = CH_DOLLAR;
                    3: b = CH_BTICK;
                    4: b = CH_NL;
                    default: ;
                endcase
                add_line_byte(b);
            end else begin
                if (b == q || b == CH_BSLASH) begin
                    b = CH_FILLER;
                end
                add_line_byte(b);
            end
        end
        if (!(may_leave_open && $urandom_range(5) == 0)) begin
            add_line_byte(q);
        end
    endfunction

    // A line of words, operators and quoted strings.
    function automatic void build_token_line();
        int  n_tok;
        logic final_tok;
        line_bytes.delete();
        n_tok = $urandom_range(1, 5);
        if ($urandom_range(7) == 0) begin
            add_line_byte(pick_separator());
        end
        for (int t = 0; t < n_tok; t++) begin
            final_tok = (t == n_tok - 1);
            // Now and then two tokens run together into one word.
            if (t > 0 && $urandom_range(5) != 0) begin
                repeat ($urandom_range(1, 2)) add_line_byte(pick_separator());
            end
            case ($urandom_range(9))
                0, 1, 2, 3: push_operator();
                4, 5: push_word();
                6: push_quoted(CH_SQUOTE, final_tok);
                7: push_quoted(CH_DQUOTE, final_tok);
                8: begin
                    add_line_byte(CH_BSLASH);
                    add_line_byte(8'($urandom_range(255)));
                end
                default: push_text($urandom_range(1) ? "\"\"" : "''");
            endcase
        end
        case ($urandom_range(5))
            0: add_line_byte(pick_separator());
            1: add_line_byte(CH_BSLASH);
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        // Bare operator, then escapes in double quotes that keep and drop the backslash.
        line_bytes.delete();
        push_text(">\t\"\\$\\q\"");
        send_line();
        // Empty word, quoted operator, and a backslash inside double quotes at line end.
        line_bytes.delete();
        push_text("\"\" '2>>' \"\\");
        send_line();
        // Zero byte, newline and all-ones byte as word bytes; operator as last word.
        line_bytes.delete();
        add_line_byte(8'h00);
        add_line_byte(CH_NL);
        add_line_byte(8'hFF);
        push_text(" 2>");
        send_line();
        // Single quote left open at line end.
        line_bytes.delete();
        push_text("'a");
        send_line();
        // A line holding nothing but a bare backslash.
        line_bytes.delete();
        add_line_byte(CH_BSLASH);
        send_line();
    endtask

    task automatic test_token_lines(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_token_line();
            sent += line_bytes.size();
            send_line();
        end
    endtask

    // Random bytes, weighted toward quotes, escapes, separators and operator characters.
    task automatic test_noise_lines(input int n_bytes);
        int sent;
        int n;
        sent = 0;
        while (sent < n_bytes) begin
            line_bytes.delete();
            n = $urandom_range(1, 10);
            repeat (n) begin
                add_line_byte($urandom_range(1) ? pick_special() : 8'($urandom_range(255)));
            end
            sent += n;
            send_line();
        end
    endtask

    initial begin
        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct  = 36;
        recv_stall_pct = 74;
        test_directed_cases();
        test_token_lines(140);
        hold_until_drained();

        send_idle_pct  = 74;
        recv_stall_pct = 36;
        test_token_lines(120);
        test_noise_lines(40);
        hold_until_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_token_lines(130);
        test_noise_lines(20);
        hold_until_drained();

        $display("Sent %0d bytes in %0d lines and checked %0d tokens.",
                 bytes_sent, lines_sent, tokens_checked);
        $display("%0d lines ended with redirect flags set; %0d mismatches.",
                 flagged_lines, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_TICKS);
        $display("Timed out with %0d tokens outstanding.", pending_tokens.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> shell_quote_tokenizer_core.f
src/sqt_pkg.sv
src/sqt_lexer.sv
src/sqt_serializer.sv
src/shell_quote_tokenizer_core.sv
bench/tb.sv
